>>> rtl/pdmq_pkg.sv
// pdmq_pkg: shared types, codes and defaults for the per-destination message queues
// no dependencies; used by every module of the block except pdmq_ram
package pdmq_pkg;

  localparam int NUM_QUEUES_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 16;

  typedef enum logic {
    CMD_SEND = 1'b0,
    CMD_GRAB = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STS_DONE  = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_FETCH
  } state_e;

  typedef struct packed {
    cmd_e        command;
    logic [3:0]  queue_id;
    logic [3:0]  sender_id;
    logic [31:0] message;
    logic [7:0]  ttl;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  out_sender;
    logic [31:0] out_message;
    logic [7:0]  out_ttl;
  } out_t;

  typedef struct packed {
    logic [3:0]  sender;
    logic [31:0] message;
    logic [7:0]  ttl;
  } rec_t;

  typedef struct packed {
    logic    accept;
    logic    send_wr;
    logic    grab_rd;
    logic    post_st;
    logic    post_rec;
    status_e code;
  } ctl_t;

  typedef struct packed {
    logic is_grab;
    logic can_send;
    logic can_grab;
  } sts_t;

endpackage

>>> rtl/pdmq_ram.sv
// pdmq_ram: generic single-write, single-read ram with registered read data
// no dependencies
module pdmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/pdmq_ctrl.sv
// pdmq_ctrl: request sequencer for the message queues
// depends on pdmq_pkg; drives pdmq_datapath through ctl_t and reads sts_t
module pdmq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  pdmq_pkg::sts_t sts,
  output pdmq_pkg::ctl_t ctl
);

  pdmq_pkg::state_e state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pdmq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    ctl          = '0;
    ctl.code     = pdmq_pkg::STS_DONE;
    busy         = 1'b1;
    case (state_r)
      pdmq_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.accept = 1'b1;
          state_nxt  = pdmq_pkg::S_CHECK;
        end
      end
      pdmq_pkg::S_CHECK: begin
        if (sts.is_grab) begin
          if (sts.can_grab) begin
            ctl.grab_rd = 1'b1;
            state_nxt   = pdmq_pkg::S_FETCH;
          end else begin
            ctl.post_st = 1'b1;
            ctl.code    = pdmq_pkg::STS_EMPTY;
            state_nxt   = pdmq_pkg::S_IDLE;
          end
        end else begin
          ctl.post_st = 1'b1;
          state_nxt   = pdmq_pkg::S_IDLE;
          if (sts.can_send) begin
            ctl.send_wr = 1'b1;
            ctl.code    = pdmq_pkg::STS_DONE;
          end else begin
            ctl.code    = pdmq_pkg::STS_FULL;
          end
        end
      end
      pdmq_pkg::S_FETCH: begin
        ctl.post_rec = 1'b1;
        state_nxt    = pdmq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = pdmq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/pdmq_datapath.sv
// pdmq_datapath: request register, per-queue pointer ram with valid bits, record ram
// and result register; depends on pdmq_pkg and pdmq_ram
module pdmq_datapath #(
  parameter int NUM_QUEUES  = pdmq_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = pdmq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pdmq_pkg::in_t  in_req,
  input  pdmq_pkg::ctl_t ctl,
  output pdmq_pkg::sts_t sts,
  output pdmq_pkg::out_t out_res,
  output logic           out_valid
);

  localparam int QW = $clog2(NUM_QUEUES);
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = 2 * PW + CW;
  localparam int RD = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW = $clog2(RD);

  pdmq_pkg::in_t    req_r;
  logic [NUM_QUEUES-1:0] valid_r;
  pdmq_pkg::out_t   out_res_r;
  logic             out_valid_r;

  logic [QW-1:0]    qidx;
  logic             in_range;
  logic [SW-1:0]    qs_rdata;
  logic [SW-1:0]    qs_wdata;
  logic             qs_we;
  logic [PW-1:0]    q_rptr, q_wptr, rptr_inc, wptr_inc;
  logic [CW-1:0]    q_cnt;
  logic [AW-1:0]    rec_base, rec_waddr, rec_raddr;
  pdmq_pkg::rec_t   rec_wdata, rec_rdata;

  assign qidx     = QW'(req_r.queue_id);
  assign in_range = 32'(req_r.queue_id) < NUM_QUEUES;

  // queue never written reads as empty with zero pointers
  always_comb begin
    if (valid_r[qidx]) begin
      q_rptr = qs_rdata[SW-1 -: PW];
      q_wptr = qs_rdata[CW +: PW];
      q_cnt  = qs_rdata[CW-1:0];
    end else begin
      q_rptr = '0;
      q_wptr = '0;
      q_cnt  = '0;
    end
  end

  assign rptr_inc = (q_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : q_rptr + 1'b1;
  assign wptr_inc = (q_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : q_wptr + 1'b1;

  assign sts.is_grab  = (req_r.command == pdmq_pkg::CMD_GRAB);
  assign sts.can_send = in_range && (q_cnt != CW'(QUEUE_DEPTH));
  assign sts.can_grab = in_range && (q_cnt != '0);

  assign qs_we    = ctl.send_wr | ctl.grab_rd;
  assign qs_wdata = ctl.send_wr ? {q_rptr, wptr_inc, q_cnt + 1'b1}
                                : {rptr_inc, q_wptr, q_cnt - 1'b1};

  pdmq_ram #(
    .WIDTH (SW),
    .DEPTH (NUM_QUEUES)
  ) u_qstate_ram (
    .clk   (clk),
    .we    (qs_we),
    .waddr (qidx),
    .wdata (qs_wdata),
    .re    (ctl.accept),
    .raddr (QW'(in_req.queue_id)),
    .rdata (qs_rdata)
  );

  assign rec_base  = AW'(qidx) * AW'(QUEUE_DEPTH);
  assign rec_waddr = rec_base + AW'(q_wptr);
  assign rec_raddr = rec_base + AW'(q_rptr);
  assign rec_wdata = '{sender: req_r.sender_id, message: req_r.message, ttl: req_r.ttl};

  pdmq_ram #(
    .WIDTH ($bits(pdmq_pkg::rec_t)),
    .DEPTH (RD)
  ) u_record_ram (
    .clk   (clk),
    .we    (ctl.send_wr),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .re    (ctl.grab_rd),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.post_st | ctl.post_rec;
      if (qs_we) begin
        valid_r[qidx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      req_r <= in_req;
    end
    if (ctl.post_st) begin
      out_res_r <= '{status: ctl.code, out_sender: '0, out_message: '0, out_ttl: '0};
    end else if (ctl.post_rec) begin
      out_res_r.status      <= pdmq_pkg::STS_DONE;
      out_res_r.out_sender  <= rec_rdata.sender;
      out_res_r.out_message <= rec_rdata.message;
      out_res_r.out_ttl     <= rec_rdata.ttl;
    end
  end

  assign out_res   = out_res_r;
  assign out_valid = out_valid_r;

endmodule

>>> rtl/per_destination_message_queues.sv
// per_destination_message_queues: top level of the per-destination message queue bank
// depends on pdmq_pkg, pdmq_ctrl, pdmq_datapath (and pdmq_ram below it)
//
//   channel   ports                      handshake
//   request   in_req, start, busy        taken on start && !busy
//   result    out_res, out_valid         one-cycle strobe, no back-pressure
//
// a send is settled in the check state, which frees busy as it returns to idle
// a grab that finds a record passes on to the fetch state (extra record ram read)
// per-queue pointers sit in a ram read at accept; valid bits make reset instant
// reset is synchronous, active low; the record store holds no reset state
// the receiver cannot stall; each result shows for exactly one cycle
module per_destination_message_queues #(
  parameter int NUM_QUEUES  = pdmq_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = pdmq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  pdmq_pkg::in_t  in_req,
  output logic           out_valid,
  output pdmq_pkg::out_t out_res
);

  pdmq_pkg::ctl_t ctl;
  pdmq_pkg::sts_t sts;

  pdmq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  pdmq_datapath #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .ctl       (ctl),
    .sts       (sts),
    .out_res   (out_res),
    .out_valid (out_valid)
  );

`ifndef SYNTHESIS
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted request did not raise busy");

  a_grab_posts: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.grab_rd |=> ctl.post_rec) else $error("grab read not followed by record post");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("two results in consecutive cycles");
`endif

endmodule

>>> test/pdmq_checker.sv
// pdmq_checker: watches the request and result channels of the message queue bank,
// predicts every result from its own copy of the queues and compares field by field
// depends on pdmq_pkg
module pdmq_checker
  import pdmq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_req,
  input  logic out_valid,
  input  out_t out_res,
  output int   errors,
  output int   outstanding,
  output int   n_sent,
  output int   n_returned,
  output int   n_empty,
  output int   n_full
);

  localparam int NQ = NUM_QUEUES_DEF;
  localparam int QD = QUEUE_DEPTH_DEF;

  rec_t mailbox_mem [NQ][QD];
  int   head_idx [NQ];
  int   tail_idx [NQ];
  int   held [NQ];
  out_t replies_due [$];

  initial begin
    errors      = 0;
    outstanding = 0;
    n_sent      = 0;
    n_returned  = 0;
    n_empty     = 0;
    n_full      = 0;
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic out_t apply_mailbox_op(in_t r);
    out_t res;
    int   q;
    res = '0;
    q = r.queue_id;
    if (r.command == CMD_SEND) begin
      if (q >= NQ || held[q] >= QD) begin
        res.status = STS_FULL;
      end else begin
        mailbox_mem[q][tail_idx[q]] = '{sender: r.sender_id, message: r.message, ttl: r.ttl};
        tail_idx[q] = (tail_idx[q] + 1) % QD;
        held[q]++;
        res.status = STS_DONE;
      end
    end else begin
      if (q >= NQ || held[q] == 0) begin
        res.status = STS_EMPTY;
      end else begin
        res.out_sender  = mailbox_mem[q][head_idx[q]].sender;
        res.out_message = mailbox_mem[q][head_idx[q]].message;
        res.out_ttl     = mailbox_mem[q][head_idx[q]].ttl;
        head_idx[q] = (head_idx[q] + 1) % QD;
        held[q]--;
        res.status = STS_DONE;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      for (int i = 0; i < NQ; i++) begin
        head_idx[i] = 0;
        tail_idx[i] = 0;
        held[i]     = 0;
      end
      replies_due.delete();
    end else begin
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          report("unexpected result", out_res, '0);
        end else begin
          want = replies_due.pop_front();
          if (out_res.status != want.status) report("status", out_res.status, want.status);
          if (out_res.out_sender != want.out_sender)
            report("sender", out_res.out_sender, want.out_sender);
          if (out_res.out_message != want.out_message)
            report("message", out_res.out_message, want.out_message);
          if (out_res.out_ttl != want.out_ttl) report("ttl", out_res.out_ttl, want.out_ttl);
          case (want.status)
            STS_FULL:  n_full++;
            STS_EMPTY: n_empty++;
            default: ;
          endcase
        end
      end
      if (start && !busy) begin
        want = apply_mailbox_op(in_req);
        replies_due.push_back(want);
        if (want.status == STS_DONE) begin
          if (in_req.command == CMD_GRAB) n_returned++;
          else n_sent++;
        end
      end
    end
    outstanding <= replies_due.size();
  end

endmodule

>>> test/tb.sv
// tb: request stimulus and verdict for per_destination_message_queues
// depends on pdmq_pkg, the block's rtl and pdmq_checker, which does all result checking
module tb;
  import pdmq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 417;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_req = '0;
  logic busy;
  logic out_valid;
  out_t out_res;
  int   errors, outstanding, n_sent, n_returned, n_empty, n_full;
  int   cycles = 0;
  int   requests = 0;

  per_destination_message_queues i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  pdmq_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_res    (out_res),
    .errors     (errors),
    .outstanding(outstanding),
    .n_sent     (n_sent),
    .n_returned (n_returned),
    .n_empty    (n_empty),
    .n_full     (n_full)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic in_t make_req(cmd_e cmd, logic [3:0] q, logic [3:0] snd,
                                   logic [31:0] msg, logic [7:0] ttl);
    in_t r;
    r.command   = cmd;
    r.queue_id  = q;
    r.sender_id = snd;
    r.message   = msg;
    r.ttl       = ttl;
    return r;
  endfunction

  task automatic issue(in_t r, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests++;
  endtask

  task automatic random_phase(int count, int idle_pct);
    in_t r;
    int  send_pct;
    logic [3:0] hot_base;
    send_pct = 50;
    hot_base = 4'($urandom_range(15));
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0: send_pct = 20;
          1: send_pct = 50;
          default: send_pct = 85;
        endcase
        hot_base = 4'($urandom_range(15));
      end
      r.command   = ($urandom_range(99) < send_pct) ? CMD_SEND : CMD_GRAB;
      r.queue_id  = ($urandom_range(99) < 75) ? hot_base + 4'($urandom_range(2))
                                              : 4'($urandom_range(15));
      r.sender_id = 4'($urandom_range(15));
      r.message   = $urandom;
      r.ttl       = 8'($urandom_range(255));
      issue(r, idle_pct);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty, extremes and back-to-back on one queue
    issue(make_req(CMD_GRAB, 4'd3, 4'd9, 32'h1234_5678, 8'h5a), 0);
    issue(make_req(CMD_SEND, 4'd0, 4'd0, 32'h0000_0000, 8'h00), 0);
    issue(make_req(CMD_SEND, 4'd15, 4'd15, 32'hffff_ffff, 8'hff), 0);
    issue(make_req(CMD_SEND, 4'd0, 4'd15, 32'hffff_ffff, 8'hff), 0);
    issue(make_req(CMD_GRAB, 4'd15, 4'd0, 32'h0, 8'h0), 0);
    issue(make_req(CMD_GRAB, 4'd0, 4'd0, 32'h0, 8'h0), 0);
    issue(make_req(CMD_GRAB, 4'd0, 4'd0, 32'h0, 8'h0), 0);
    issue(make_req(CMD_GRAB, 4'd0, 4'd0, 32'h0, 8'h0), 0);
    // fill one queue to the brim, then one send too many
    for (int i = 0; i < 17; i++) begin
      issue(make_req(CMD_SEND, 4'd9, 4'(i), 32'ha5a5_0000 | 32'(i), 8'(8'h80 + i)), 0);
    end

    random_phase(PHASE_ITEMS, 21);
    random_phase(PHASE_ITEMS, 48);
    random_phase(PHASE_ITEMS, 0);
    start <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d requests: %0d sends stored, %0d records grabbed, %0d grabs on empty",
             requests, n_sent, n_returned, n_empty);
    $display("%0d sends dropped on full queues, %0d mismatches", n_full, errors);
    if (errors == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
